>>> design/assert_macros.svh
// Assertion macros shared by the pulse analyzer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define PBA_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the module's clk and arst_n.
`define PBA_ASSERT(lbl, prop, msg) \
	`PBA_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

>>> design/pba_pkg.sv
// Types and constants for the pulse baseline / peak / width analyzer.
`timescale 1ns / 1ps
package pba_pkg;

	localparam int FRAC       = 8;
	localparam int THR_MULT   = 3;

	localparam int UW         = 72;
	localparam int DVS_W      = 32;
	localparam int CNT_W      = 7;
	localparam int SUM_W      = 29;
	localparam int SQ_W       = 43;
	localparam int NUM_W      = 39;
	localparam int BL_W       = 24;
	localparam int D_W        = 26;
	localparam int SIG_W      = 24;
	localparam int TH_W       = 26;
	localparam int INT_W      = 35;
	localparam int PW_W       = 12;
	localparam int PK_W       = 24;

	localparam int MUL_STEPS  = DVS_W;
	localparam int DIV_STEPS  = UW;
	localparam int SQRT_STEPS = UW / 2;

	localparam logic [10:0] BASE_END_RST  = 11'd60;
	localparam logic [9:0]  WIN_START_RST = 10'd100;
	localparam logic [10:0] WIN_END_RST   = 11'd200;

	typedef enum logic [1:0] {
		CFG_BASE_END  = 2'd0,
		CFG_WIN_START = 2'd1,
		CFG_WIN_END   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		UOP_MUL,
		UOP_DIV,
		UOP_SQRT
	} uop_t;

	typedef struct packed {
		logic             start;
		uop_t             op;
		logic [UW-1:0]    a;
		logic [DVS_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [UW-1:0] result;
	} unit_rsp_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_BASE,
		ST_BASE_DRAIN,
		ST_BL_DIV,
		ST_MUL_NSQ,
		ST_MUL_SUM,
		ST_VAR_DIV,
		ST_SQRT,
		ST_WIN,
		ST_WIN_DRAIN,
		ST_LPREP,
		ST_LSCAN,
		ST_RSCAN,
		ST_DONE
	} state_t;

endpackage

>>> design/pba_store.sv
// Sample store: one write port, one registered read port.
`timescale 1ns / 1ps
module pba_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic signed [15:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic signed [15:0] rd_data
);

	logic signed [15:0] mem [DEPTH];
	logic signed [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/pba_unit.sv
// Shared iterative unit: shift-add multiply, restoring divide, square root.
`timescale 1ns / 1ps
module pba_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  pba_pkg::unit_req_t req,
	output pba_pkg::unit_rsp_t rsp
);
	import pba_pkg::*;

	logic             busy_q;
	logic             done_q;
	uop_t             op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [UW-1:0]    acc_q;
	logic [UW-1:0]    opa_q;
	logic [UW-1:0]    opb_q;

	logic [UW-1:0]    acc_n;
	logic [UW-1:0]    opa_n;
	logic [UW-1:0]    opb_n;
	logic [DVS_W:0]   rem_c;
	logic [UW-1:0]    trial_c;

	// one step of the selected operation
	always_comb begin
		acc_n   = acc_q;
		opa_n   = opa_q;
		opb_n   = opb_q;
		rem_c   = {acc_q[DVS_W-1:0], opa_q[UW-1]};
		trial_c = opa_q + opb_q;
		case (op_q)
			UOP_MUL: begin
				if (opb_q[0]) begin
					acc_n = acc_q + opa_q;
				end
				opa_n = opa_q << 1;
				opb_n = opb_q >> 1;
			end
			UOP_DIV: begin
				if (rem_c >= {1'b0, opb_q[DVS_W-1:0]}) begin
					acc_n = UW'(rem_c - {1'b0, opb_q[DVS_W-1:0]});
					opa_n = {opa_q[UW-2:0], 1'b1};
				end else begin
					acc_n = UW'(rem_c);
					opa_n = {opa_q[UW-2:0], 1'b0};
				end
			end
			UOP_SQRT: begin
				if (acc_q >= trial_c) begin
					acc_n = acc_q - trial_c;
					opa_n = (opa_q >> 1) + opb_q;
				end else begin
					opa_n = opa_q >> 1;
				end
				opb_n = opb_q >> 2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= UOP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					UOP_DIV:  cnt_q <= CNT_W'(DIV_STEPS - 1);
					UOP_SQRT: cnt_q <= CNT_W'(SQRT_STEPS - 1);
					default:  cnt_q <= CNT_W'(MUL_STEPS - 1);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				UOP_SQRT: begin
					acc_q <= req.a;
					opa_q <= '0;
					opb_q <= UW'(1) << (UW - 2);
				end
				default: begin
					acc_q <= '0;
					opa_q <= req.a;
					opb_q <= UW'(req.b);
				end
			endcase
		end else if (busy_q) begin
			acc_q <= acc_n;
			opa_q <= opa_n;
			opb_q <= opb_n;
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = (op_q == UOP_MUL) ? acc_q : opa_q;

endmodule

>>> design/pulse_baseline_peak_width_analyzer.sv
// Top level of the pulse baseline / peak / width analyzer with its sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input channel (in_valid / in_stall, sample, last): one sample per item.
//   Samples are taken one per cycle while loading; item n goes to store entry n,
//   samples past SAMPLES are dropped. An item with last set closes the event.
//   After the closing item in_stall stays high while the event is analyzed:
//   the baseline pass, the window pass and both scans go through the store's
//   single read port (one sample per cycle per pass), and the shared
//   multiply/divide/sqrt unit runs two 72-step divides, two 32-step multiplies
//   and a 36-step square root.
//   Output channel (out_valid / out_stall): one result item per event, held
//   in an output register. While it waits the next event loads; a second
//   result waits in the sequencer until the first one is taken.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while the block is idle.
//   Reset clears the write index, the control state and loads the register
//   defaults (60, 100, 200). Store contents are undefined until written.
module pulse_baseline_peak_width_analyzer #(
	parameter int SAMPLES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [15:0]        sample,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [pba_pkg::PK_W-1:0]  peak_height,
	output logic signed [pba_pkg::INT_W-1:0] charge_integral,
	output logic signed [pba_pkg::PW_W-1:0]  pulse_width,
	output logic signed [pba_pkg::BL_W-1:0]  baseline_level,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [10:0]               cfg_data
);
	import pba_pkg::*;

	localparam int AW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int WW  = $clog2(SAMPLES + 1);
	localparam int CW  = (WW > 11) ? WW : 11;

	// configuration
	logic [10:0] base_end_q;
	logic [9:0]  win_start_q;
	logic [10:0] win_end_q;

	state_t state_q, state_n;

	logic [WW-1:0] wr_idx_q;
	logic [CW-1:0] idx_q;
	logic          ustart_q;

	logic                    rd_vld_s1;
	state_t                  rd_tag_s1;
	logic [CW-1:0]           rd_idx_s1;

	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic [UW-1:0]           m_q;
	logic signed [BL_W-1:0]  bl_q;
	logic [TH_W-1:0]         thr_q;
	logic signed [INT_W-1:0] integ_q;
	logic signed [D_W-1:0]   vmax_q;
	logic [CW-1:0]           pos_q;
	logic [CW-1:0]           lb_q;
	logic [CW-1:0]           rb_q;

	logic                    out_valid_q;
	logic [PK_W-1:0]         peak_q;
	logic signed [INT_W-1:0] charge_q;
	logic signed [PW_W-1:0]  width_q;
	logic signed [BL_W-1:0]  level_q;

	unit_req_t req;
	unit_rsp_t rsp;

	logic          in_acc;
	logic          wr_en;
	logic          rd_en;
	logic          res_load;
	logic          unit_state;

	logic [CW-1:0] n_c;
	logic [CW-1:0] ws_c;
	logic [CW-1:0] we_c;
	logic [CW:0]   d2n_c;
	logic [2*CW-1:0] den_c;

	logic signed [15:0]      rd_data;
	logic signed [31:0]      sq_c;
	logic signed [NUM_W-1:0] num_c;
	logic [NUM_W-1:0]        num_abs_c;
	logic [SUM_W-1:0]        sum_abs_c;
	logic [NUM_W-1:0]        quo_c;
	logic signed [D_W-1:0]   d_c;
	logic                    below_c;
	logic                    l_more;
	logic                    r_more;
	logic                    l_data;
	logic                    r_data;
	logic                    l_hit;
	logic                    r_hit;
	logic                    l_leave;
	logic                    r_leave;

	assign in_acc   = in_valid && !in_stall;
	assign wr_en    = in_acc && (wr_idx_q < WW'(SAMPLES));
	assign res_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// clamp the baseline end and window end values into the store range
	always_comb begin
		if (CW'(base_end_q) < CW'(2)) begin
			n_c = CW'(2);
		end else if (CW'(base_end_q) > CW'(SAMPLES)) begin
			n_c = CW'(SAMPLES);
		end else begin
			n_c = CW'(base_end_q);
		end
		ws_c = CW'(win_start_q);
		we_c = (CW'(win_end_q) > CW'(SAMPLES)) ? CW'(SAMPLES) : CW'(win_end_q);
	end

	assign d2n_c = {n_c, 1'b0};
	assign den_c = (2*CW)'(n_c) * (2*CW)'(n_c - CW'(1));

	// rounded mean: floor((sum*2^(F+1) + n) / 2n), negative side via ceiling
	assign num_c     = (NUM_W'(sum_q) <<< (FRAC + 1)) + NUM_W'(n_c);
	assign num_abs_c = num_c[NUM_W-1] ? NUM_W'(-num_c + NUM_W'(d2n_c) - NUM_W'(1))
	                                  : NUM_W'(num_c);
	assign sum_abs_c = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo_c     = rsp.result[NUM_W-1:0];

	// full-width square of the returning sample
	assign sq_c = 32'(rd_data) * 32'(rd_data);

	// excess of the returning sample over baseline
	assign d_c     = (D_W'(rd_data) <<< FRAC) - D_W'(bl_q);
	assign below_c = $signed({d_c[D_W-1], d_c}) < $signed({1'b0, thr_q});

	assign l_more  = idx_q > ws_c;
	assign r_more  = idx_q < we_c;
	assign l_data  = rd_vld_s1 && (rd_tag_s1 == ST_LSCAN);
	assign r_data  = rd_vld_s1 && (rd_tag_s1 == ST_RSCAN);
	assign l_hit   = (state_q == ST_LSCAN) && l_data && below_c;
	assign r_hit   = (state_q == ST_RSCAN) && r_data && below_c;
	// leave a scan on a hit, or once nothing is issued and nothing returns
	assign l_leave = l_hit || (!l_more && !l_data);
	assign r_leave = r_hit || (!r_more && !r_data);

	pba_store #(
		.DEPTH (SAMPLES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_q[AW-1:0]),
		.wr_data (sample),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	pba_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_LOAD:       if (in_acc && last) state_n = ST_BASE;
			ST_BASE:       if (idx_q == n_c - CW'(1)) state_n = ST_BASE_DRAIN;
			ST_BASE_DRAIN: state_n = ST_BL_DIV;
			ST_BL_DIV:     if (rsp.done) state_n = ST_MUL_NSQ;
			ST_MUL_NSQ:    if (rsp.done) state_n = ST_MUL_SUM;
			ST_MUL_SUM:    if (rsp.done) state_n = ST_VAR_DIV;
			ST_VAR_DIV:    if (rsp.done) state_n = ST_SQRT;
			ST_SQRT: begin
				if (rsp.done) begin
					state_n = (ws_c < we_c) ? ST_WIN : ST_LPREP;
				end
			end
			ST_WIN:        if (idx_q == we_c - CW'(1)) state_n = ST_WIN_DRAIN;
			ST_WIN_DRAIN:  state_n = ST_LPREP;
			ST_LPREP:      state_n = ST_LSCAN;
			ST_LSCAN:      if (l_leave) state_n = ST_RSCAN;
			ST_RSCAN:      if (r_leave) state_n = ST_DONE;
			ST_DONE:       if (res_load) state_n = ST_LOAD;
			default:       state_n = ST_LOAD;
		endcase
	end

	// sequencer outputs: store reads, unit requests, input stall
	always_comb begin
		in_stall   = (state_q != ST_LOAD);
		rd_en      = 1'b0;
		unit_state = 1'b0;
		req.op     = UOP_MUL;
		req.a      = '0;
		req.b      = '0;
		unique case (state_q)
			ST_BASE, ST_WIN: rd_en = 1'b1;
			ST_LSCAN:        rd_en = l_more;
			ST_RSCAN:        rd_en = r_more;
			ST_BL_DIV: begin
				unit_state = 1'b1;
				req.op     = UOP_DIV;
				req.a      = UW'(num_abs_c);
				req.b      = DVS_W'(d2n_c);
			end
			ST_MUL_NSQ: begin
				unit_state = 1'b1;
				req.op     = UOP_MUL;
				req.a      = UW'(sumsq_q);
				req.b      = DVS_W'(n_c);
			end
			ST_MUL_SUM: begin
				unit_state = 1'b1;
				req.op     = UOP_MUL;
				req.a      = UW'(sum_abs_c);
				req.b      = DVS_W'(sum_abs_c);
			end
			ST_VAR_DIV: begin
				unit_state = 1'b1;
				req.op     = UOP_DIV;
				req.a      = m_q << (2 * FRAC);
				req.b      = DVS_W'(den_c);
			end
			ST_SQRT: begin
				unit_state = 1'b1;
				req.op     = UOP_SQRT;
				req.a      = m_q;
			end
			default: begin
			end
		endcase
		req.start = unit_state && !ustart_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			wr_idx_q    <= '0;
			ustart_q    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			base_end_q  <= BASE_END_RST;
			win_start_q <= WIN_START_RST;
			win_end_q   <= WIN_END_RST;
		end else begin
			state_q   <= state_n;
			rd_vld_s1 <= rd_en;
			if (req.start) begin
				ustart_q <= 1'b1;
			end else if (rsp.done) begin
				ustart_q <= 1'b0;
			end
			// advance the write index, drop samples past the store
			if (in_acc) begin
				if (last) begin
					wr_idx_q <= '0;
				end else if (wr_en) begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_BASE_END:  base_end_q  <= cfg_data;
					CFG_WIN_START: win_start_q <= cfg_data[9:0];
					CFG_WIN_END:   win_end_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_tag_s1 <= state_q;
		rd_idx_s1 <= idx_q;

		// read index
		if (in_acc && last) begin
			idx_q <= '0;
		end else if (state_q == ST_SQRT && rsp.done) begin
			idx_q <= ws_c;
		end else if (state_q == ST_LPREP || (state_q == ST_LSCAN && l_leave)) begin
			idx_q <= pos_q;
		end else if (state_q == ST_LSCAN && l_more) begin
			idx_q <= idx_q - 1'b1;
		end else if (rd_en) begin
			idx_q <= idx_q + 1'b1;
		end

		if (in_acc && last) begin
			sum_q   <= '0;
			sumsq_q <= '0;
			integ_q <= '0;
			vmax_q  <= '0;
			pos_q   <= '0;
			lb_q    <= '0;
			rb_q    <= '0;
		end else begin
			if (rd_vld_s1 && rd_tag_s1 == ST_BASE) begin
				sum_q   <= sum_q + SUM_W'(rd_data);
				sumsq_q <= sumsq_q + SQ_W'($unsigned(sq_c));
			end
			if (rd_vld_s1 && rd_tag_s1 == ST_WIN) begin
				integ_q <= integ_q + INT_W'(d_c);
				if (d_c > vmax_q) begin
					vmax_q <= d_c;
					pos_q  <= rd_idx_s1;
				end
			end
			if (l_hit) begin
				lb_q <= rd_idx_s1;
			end
			if (r_hit) begin
				rb_q <= rd_idx_s1;
			end
		end

		if (rsp.done) begin
			unique case (state_q)
				ST_BL_DIV:  bl_q <= num_c[NUM_W-1] ? BL_W'(-quo_c) : BL_W'(quo_c);
				ST_MUL_NSQ: m_q  <= rsp.result;
				ST_MUL_SUM: m_q  <= m_q - rsp.result;
				ST_VAR_DIV: m_q  <= rsp.result;
				ST_SQRT:    thr_q <= TH_W'(rsp.result[SIG_W-1:0]) * TH_W'(THR_MULT);
				default: begin
				end
			endcase
		end

		// hold the result register until the receiver takes it
		if (res_load) begin
			peak_q   <= vmax_q[PK_W-1:0];
			charge_q <= integ_q;
			width_q  <= PW_W'(rb_q) - PW_W'(lb_q) - PW_W'(2);
			level_q  <= bl_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign peak_height     = peak_q;
	assign charge_integral = charge_q;
	assign pulse_width     = width_q;
	assign baseline_level  = level_q;

	`PBA_ASSERT(a_unit_idle_start, req.start |-> !rsp.busy, "unit started while busy")
	`PBA_ASSERT(a_wr_idx_range, 1'b1 |-> (wr_idx_q <= WW'(SAMPLES)), "write index past store")
	`PBA_ASSERT(a_last_stalls, (in_acc && last) |=> in_stall, "input not stalled after last")
	`PBA_ASSERT(a_no_overwrite, res_load |-> (!out_valid_q || !out_stall), "result overwritten")

endmodule

>>> verif/tb_pulse_baseline_peak_width_analyzer.sv
// Self-checking testbench for the pulse baseline / peak / width analyzer.
`timescale 1ns / 1ps
module tb_pulse_baseline_peak_width_analyzer;
	import pba_pkg::*;

	localparam int DEPTH = 1024;

	typedef struct {
		logic signed [15:0] s;
		logic               lst;
	} sample_item_t;

	typedef struct {
		logic [23:0]        peak;
		logic signed [34:0] charge;
		logic signed [11:0] width;
		logic signed [23:0] base;
	} pulse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] sample = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PK_W-1:0] peak_height;
	logic signed [INT_W-1:0] charge_integral;
	logic signed [PW_W-1:0] pulse_width;
	logic signed [BL_W-1:0] baseline_level;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [10:0] cfg_data = '0;

	// Predictor state: its own copy of the store and the registers.
	logic signed [15:0] trace_mem [DEPTH];
	int unsigned wr_ptr;
	int unsigned base_end_r, win_start_r, win_end_r;

	sample_item_t  sample_q[$];
	pulse_result_t pulse_q[$];
	int errors = 0;
	int idle_pct = 20;
	int n_items = 0;

	always #2 clk = ~clk;

	pulse_baseline_peak_width_analyzer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.peak_height(peak_height), .charge_integral(charge_integral),
		.pulse_width(pulse_width), .baseline_level(baseline_level),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Compute baseline, sigma threshold, charge, peak and width of the stored event.
	function automatic pulse_result_t analyze_event();
		pulse_result_t r;
		longint n, we, ws, sum, sumsq, v, bl, thr, integ, vmax, d, lb, rb, k, pos;
		longint unsigned m, den, qq, rr, var_fx;
		n = base_end_r;
		if (n < 2) n = 2;
		if (n > DEPTH) n = DEPTH;
		we = (win_end_r > DEPTH) ? DEPTH : win_end_r;
		ws = win_start_r;
		sum = 0;
		sumsq = 0;
		for (longint i = 0; i < n; i++) begin
			v = trace_mem[i];
			sum += v;
			sumsq += v * v;
		end
		bl = floor_quot(sum * 512 + n, 2 * n);
		m = n * sumsq - sum * sum;
		den = n * (n - 1);
		qq = m / den;
		rr = m % den;
		var_fx = (qq << 16) + ((rr << 16) / den);
		thr = longint'(int_sqrt(var_fx)) * 3;
		integ = 0;
		vmax = 0;
		pos = 0;
		for (longint j = ws; j < we; j++) begin
			d = longint'(trace_mem[j]) * 256 - bl;
			integ += d;
			if (d > vmax) begin
				vmax = d;
				pos = j;
			end
		end
		lb = 0;
		rb = 0;
		for (k = pos; k > ws; k--) begin
			if (longint'(trace_mem[k]) * 256 - bl < thr) begin
				lb = k;
				break;
			end
		end
		for (k = pos; k < we; k++) begin
			if (longint'(trace_mem[k]) * 256 - bl < thr) begin
				rb = k;
				break;
			end
		end
		r.peak = vmax[23:0];
		r.charge = integ[34:0];
		r.width = 12'((rb - 1) - (lb + 1));
		r.base = bl[23:0];
		return r;
	endfunction

	// Driver: present queued samples, advance on acceptance, predict results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (wr_ptr < DEPTH) begin
					trace_mem[wr_ptr] = sample;
					wr_ptr++;
				end
				if (last) begin
					wr_ptr = 0;
					pulse_q.push_back(analyze_event());
				end
				void'(sample_q.pop_front());
			end
			// hold a presented item until it is taken
			if (!in_valid || !in_stall) begin
				if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					sample <= sample_q[0].s;
					last <= sample_q[0].lst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back pressure, compare each taken result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pulse_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: peak %0d charge %0d width %0d base %0d",
							peak_height, charge_integral, pulse_width, baseline_level);
				end else begin
					if (peak_height !== pulse_q[0].peak || charge_integral !== pulse_q[0].charge ||
						pulse_width !== pulse_q[0].width || baseline_level !== pulse_q[0].base) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								pulse_q[0].peak, pulse_q[0].charge, pulse_q[0].width,
								pulse_q[0].base, peak_height, charge_integral,
								pulse_width, baseline_level);
					end
					void'(pulse_q.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[10:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_BASE_END:  base_end_r = val & 11'h7FF;
			CFG_WIN_START: win_start_r = val & 10'h3FF;
			default:       win_end_r = val & 11'h7FF;
		endcase
	endtask

	task automatic set_regs(int unsigned be, int unsigned ws, int unsigned we);
		write_reg(CFG_BASE_END, be);
		write_reg(CFG_WIN_START, ws);
		write_reg(CFG_WIN_END, we);
	endtask

	task automatic push_sample(int v, bit lst);
		sample_item_t it;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		it.s = v[15:0];
		it.lst = lst;
		sample_q.push_back(it);
		n_items++;
	endtask

	// Queue one event: a noisy baseline with an optional pulse, or pure noise.
	task automatic push_event(int len);
		int base, noise, amp, p0, pw, v;
		bit wild;
		wild = ($urandom_range(99) < 20);
		base = $urandom_range(4000) - 2000;
		noise = $urandom_range(200);
		amp = $urandom_range(30000) - 5000;
		p0 = $urandom_range(len);
		pw = $urandom_range(20) + 1;
		for (int i = 0; i < len; i++) begin
			if (wild)
				v = $urandom_range(65535) - 32768;
			else
				v = base + $urandom_range(2 * noise) - noise + ((i >= p0 && i < p0 + pw) ? amp : 0);
			push_sample(v, i == len - 1);
		end
	endtask

	// Let everything queued drain, then settle before touching registers.
	task automatic drain();
		while (sample_q.size() > 0 || pulse_q.size() > 0 || in_valid)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		base_end_r = BASE_END_RST;
		win_start_r = WIN_START_RST;
		win_end_r = WIN_END_RST;
		wr_ptr = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the whole store first so no later read hits an unwritten entry;
		// extremes of the sample range sit inside the default window. The event
		// runs past the store: extra samples are dropped, the last mark still closes.
		for (int i = 0; i < DEPTH + 6; i++)
			push_sample((i == 120) ? 32767 : (i == 130) ? -32768 :
				(i >= 140 && i < 150) ? 9000 : $urandom_range(40) - 20, i == DEPTH + 5);
		// short event keeps old entries
		push_sample(-32768, 1'b1);
		push_event(3);
		drain();

		// extremes and clamping of the registers, including an empty window
		set_regs(2, 0, 1);
		push_event(12);
		drain();
		set_regs(DEPTH, DEPTH - 1, DEPTH);
		push_event(40);
		drain();
		set_regs(0, 50, 10);
		push_event(20);
		drain();
		set_regs(2047, 1023, 2047);
		push_event(30);
		drain();
		set_regs(1, 5, 5);
		push_event(8);
		drain();

		// random phases, mostly small sizes; one stretch without idling
		for (int ph = 0; n_items < 1900; ph++) begin
			idle_pct = (ph == 1) ? 0 : 20;
			if (ph % 7 == 6)
				set_regs($urandom_range(2047), $urandom_range(1023), $urandom_range(2047));
			else
				set_regs($urandom_range(64) + 2, $urandom_range(80),
					$urandom_range(128) + 1);
			repeat ($urandom_range(5) + 2)
				push_event($urandom_range(80) + 1);
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0 && pulse_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#40ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
